// ===== rtl/sfd_pkg.sv =====
// Shared types and codes for the serial frame deframer.
// No dependencies; the parser, queue, replay and top-level files refer to this package by scoped names.
package sfd_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic REG_START_CODE = 1'b0;
  localparam logic REG_STOP_CODE  = 1'b1;

  localparam logic [ByteW-1:0] START_CODE_RST = 8'h33;
  localparam logic [ByteW-1:0] STOP_CODE_RST  = 8'h99;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_DATA  = 3'd2,
    PH_CHECK = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RP_IDLE  = 2'd0,
    RP_FETCH = 2'd1,
    RP_LOAD  = 2'd2
  } rp_state_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic wr_bank;
    logic rd_bank;
  } q_status_t;

endpackage

// ===== rtl/sfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sfd_parser.sv =====
// Front end: hunts for frames, checks length, checksum and stop byte,
// writes payload into the RAM bank and posts a frame length. Uses sfd_pkg.
module sfd_parser #(
  parameter int unsigned MAX_PAYLOAD = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [sfd_pkg::ByteW-1:0] in_byte,
  input  logic [sfd_pkg::ByteW-1:0] start_code,
  input  logic [sfd_pkg::ByteW-1:0] stop_code,
  input  sfd_pkg::q_status_t      q_status,
  output logic                    ram_wr_en,
  output logic [AW:0]             ram_wr_addr,
  output logic [sfd_pkg::ByteW-1:0] ram_wr_data,
  output logic                    push,
  output logic [CW-1:0]           push_len
);

  localparam logic [sfd_pkg::ByteW-1:0] MaxLen = sfd_pkg::ByteW'(MAX_PAYLOAD);

  sfd_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] expected_r, expected_nxt;
  logic [CW-1:0] received_r, received_nxt;
  logic [sfd_pkg::ByteW-1:0] xor_r, xor_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sfd_pkg::PH_HUNT;
      expected_r <= '0;
      received_r <= '0;
      xor_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      expected_r <= expected_nxt;
      received_r <= received_nxt;
      xor_r      <= xor_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    expected_nxt = expected_r;
    received_nxt = received_r;
    xor_nxt      = xor_r;
    ram_wr_en    = 1'b0;
    push         = 1'b0;
    if (accept) begin
      unique case (phase_r)
        sfd_pkg::PH_LEN: begin
          if (in_byte == '0 || in_byte > MaxLen) begin
            phase_nxt = sfd_pkg::PH_HUNT;
          end else begin
            expected_nxt = in_byte[CW-1:0];
            received_nxt = '0;
            xor_nxt      = '0;
            phase_nxt    = sfd_pkg::PH_DATA;
          end
        end
        sfd_pkg::PH_DATA: begin
          ram_wr_en    = 1'b1;
          xor_nxt      = xor_r ^ in_byte;
          received_nxt = received_r + CW'(1);
          if (received_nxt >= expected_r) begin
            phase_nxt = sfd_pkg::PH_CHECK;
          end
        end
        sfd_pkg::PH_CHECK: begin
          phase_nxt = (in_byte == xor_r) ? sfd_pkg::PH_STOP : sfd_pkg::PH_HUNT;
        end
        sfd_pkg::PH_STOP: begin
          push      = (in_byte == stop_code);
          phase_nxt = sfd_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = (in_byte == start_code) ? sfd_pkg::PH_LEN : sfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  assign ram_wr_addr = {q_status.wr_bank, received_r[AW-1:0]};
  assign ram_wr_data = in_byte;
  assign push_len    = expected_r;

endmodule

// ===== rtl/sfd_queue.sv =====
// Two-entry queue of validated frame lengths; entry slot doubles as RAM bank.
// Uses sfd_pkg.
module sfd_queue #(
  parameter int unsigned CW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [CW-1:0]      push_len,
  input  logic               pop,
  output logic [CW-1:0]      head_len,
  output sfd_pkg::q_status_t status
);

  logic [CW-1:0] len_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      len_r[wr_ptr_r] <= push_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head_len       = len_r[rd_ptr_r];
  assign status.empty   = (count_r == 2'd0);
  assign status.full    = (count_r == 2'd2);
  assign status.wr_bank = wr_ptr_r;
  assign status.rd_bank = rd_ptr_r;

endmodule

// ===== rtl/sfd_replay.sv =====
// Back end: reads a posted frame out of its RAM bank and drives the
// result register, marking the final byte. Uses sfd_pkg.
module sfd_replay #(
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfd_pkg::q_status_t        q_status,
  input  logic [CW-1:0]             head_len,
  output logic                      pop,
  output logic                      ram_rd_en,
  output logic [AW:0]               ram_rd_addr,
  input  logic [sfd_pkg::ByteW-1:0] ram_rd_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [sfd_pkg::ByteW-1:0] out_payload_byte,
  output logic                      out_last_byte
);

  sfd_pkg::rp_state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          valid_r, valid_nxt;
  logic [sfd_pkg::ByteW-1:0] byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic          is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfd_pkg::RP_IDLE;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign is_last = ((CW'(idx_r) + CW'(1)) == head_len);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    ram_rd_en = 1'b0;
    unique case (state_r)
      sfd_pkg::RP_IDLE: begin
        idx_nxt = '0;
        if (!q_status.empty) begin
          state_nxt = sfd_pkg::RP_FETCH;
        end
      end
      sfd_pkg::RP_FETCH: begin
        ram_rd_en = 1'b1;
        state_nxt = sfd_pkg::RP_LOAD;
      end
      sfd_pkg::RP_LOAD: begin
        if (!valid_r || !out_stall) begin
          valid_nxt = 1'b1;
          byte_nxt  = ram_rd_data;
          last_nxt  = is_last;
          if (is_last) begin
            pop       = 1'b1;
            state_nxt = sfd_pkg::RP_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = sfd_pkg::RP_FETCH;
          end
        end
      end
      default: begin
        state_nxt = sfd_pkg::RP_IDLE;
      end
    endcase
  end

  assign ram_rd_addr      = {q_status.rd_bank, idx_r};
  assign out_valid        = valid_r;
  assign out_payload_byte = byte_r;
  assign out_last_byte    = last_r;

endmodule

// ===== rtl/serial_frame_deframer.sv =====
// Top level of the serial frame deframer: register port, parser, length
// queue, two-bank payload RAM and replay. Uses sfd_pkg and all sfd_* modules.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid / in_stall          in_byte
//   out      output     out_valid / out_stall        out_payload_byte, out_last_byte
//   cfg      input      cfg_psel/penable/pwrite      cfg_paddr, cfg_pwdata, cfg_prdata
//
// One input byte is taken per cycle while fewer than two validated frames wait.
// Within a frame the replay unit issues a RAM read for each payload byte, then loads the
// registered read data into the output register. Between frames it passes through its idle
// state; out_stall holds the byte.
// in_stall is high while both RAM banks hold frames not yet replayed.
// Reset clears control state only; the payload RAM is not cleared.
module serial_frame_deframer #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_byte,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned RamDepth = 2 * (1 << AW);

  logic [7:0] start_code_r;
  logic [7:0] stop_code_r;
  logic       cfg_wr;
  logic       accept;

  sfd_pkg::q_status_t q_status;
  logic          push;
  logic [CW-1:0] push_len;
  logic          pop;
  logic [CW-1:0] head_len;
  logic          ram_wr_en;
  logic [AW:0]   ram_wr_addr;
  logic [7:0]    ram_wr_data;
  logic          ram_rd_en;
  logic [AW:0]   ram_rd_addr;
  logic [7:0]    ram_rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= sfd_pkg::START_CODE_RST;
      stop_code_r  <= sfd_pkg::STOP_CODE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        sfd_pkg::REG_START_CODE: start_code_r <= cfg_pwdata[7:0];
        sfd_pkg::REG_STOP_CODE:  stop_code_r  <= cfg_pwdata[7:0];
        default:                 start_code_r <= start_code_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      sfd_pkg::REG_START_CODE: cfg_prdata = {24'd0, start_code_r};
      sfd_pkg::REG_STOP_CODE:  cfg_prdata = {24'd0, stop_code_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  sfd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW(AW),
    .CW(CW)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_byte),
    .start_code (start_code_r),
    .stop_code  (stop_code_r),
    .q_status   (q_status),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .push       (push),
    .push_len   (push_len)
  );

  sfd_queue #(
    .CW(CW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_len(push_len),
    .pop     (pop),
    .head_len(head_len),
    .status  (q_status)
  );

  sfd_ram #(
    .WIDTH(8),
    .DEPTH(RamDepth)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  sfd_replay #(
    .AW(AW),
    .CW(CW)
  ) u_replay (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .head_len        (head_len),
    .pop             (pop),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule
